// File: rtl/swm_pkg.sv
package swm_pkg;

    localparam int SMP_W  = 8;
    localparam int FILL_W = 7;
    localparam int LEN_W  = 7;
    // Ages and cell positions are 8 bits; the 7-bit length caps the window at 127.
    localparam int AGE_W  = 8;
    localparam int POS_W  = 8;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

    // Register byte addresses
    localparam logic [2:0] ADDR_WINDOW_LENGTH = 3'd0;

    typedef struct packed {
        logic                    valid;
        logic signed [SMP_W-1:0] val;
        logic [AGE_W-1:0]        age;
    } swm_entry_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                    en;       // update this cycle
        logic                    del;      // drop the oldest entry
        logic [POS_W-1:0]        del_pos;  // sorted position of the oldest entry
        logic                    dec;      // age every survivor by one
        logic signed [SMP_W-1:0] smp;      // new sample
        logic [AGE_W-1:0]        new_age;  // age tag of the new sample
    } swm_ctl_t;

endpackage

// File: rtl/sliding_window_median.sv
// Channel  | Signals                           | Direction | Beat
// ---------+-----------------------------------+-----------+---------------------------
// input    | in_valid, in_ready, sample        | in        | one signed 8-bit sample
// output   | out_valid, out_ready, median,fill | out       | median and fill of window
// config   | psel,penable,pwrite,paddr,pwdata, | in/out    | window_length at address 0
//          | prdata, pready                    |           |
//
// One sample per clock while the output is not stalled: the sorted cell row inserts
// and evicts in the same update, so the sorted-row update sets the rate. The result
// appears in the cycle after the input beat, from the registered cell row.
// Reset leaves one valid cell holding zero, fill one, window_length 64.
// A stalled output holds the row; the input is taken again once the pending
// result beat goes out (same-cycle hand-over allowed).
module sliding_window_median #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [7:0]           sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [7:0]           median,
    output logic [6:0]                  fill,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import swm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    // Configuration
    logic [LEN_W-1:0] wlen_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wlen_reg <= LEN_RESET;
        else if (cfg_wr && paddr == ADDR_WINDOW_LENGTH)
            wlen_reg <= pwdata[LEN_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_WINDOW_LENGTH)
            prdata = {{(32 - LEN_W){1'b0}}, wlen_reg};
    end

    // Effective length, clamped to 1..MAX_WINDOW
    logic [CNT_W-1:0] len_eff;

    always_comb
    begin
        if (wlen_reg == '0)
            len_eff = CNT_W'(1);
        else if (int'(wlen_reg) > MAX_WINDOW)
            len_eff = CNT_W'(MAX_WINDOW);
        else
            len_eff = CNT_W'(wlen_reg);
    end

    // Handshake
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Cell row, ascending by value; the age tag gives arrival order (0 = oldest)
    swm_entry_t cell_q [MAX_WINDOW];
    swm_ctl_t   ctl;
    logic [MAX_WINDOW-1:0] valid_vec;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            swm_entry_t lq, rq;
            if (gi == 0)
            begin : g_first
                assign lq = '0;
            end
            else
            begin : g_mid_l
                assign lq = cell_q[gi-1];
            end
            if (gi == MAX_WINDOW - 1)
            begin : g_last
                assign rq = '0;
            end
            else
            begin : g_mid_r
                assign rq = cell_q[gi+1];
            end
            swm_cell #(.IDX(gi)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .left_q  (lq),
                .right_q (rq),
                .q       (cell_q[gi])
            );
            assign valid_vec[gi] = cell_q[gi].valid;
        end
    endgenerate

    // Locate the oldest entry and pick the median tap; each is a one-hot OR.
    logic signed [SMP_W-1:0] oldest_val;
    logic [POS_W-1:0]        oldest_pos;
    logic signed [SMP_W-1:0] med_val;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        med_idx;

    assign med_idx = fill_reg >> 1;

    always_comb
    begin
        oldest_val = '0;
        oldest_pos = '0;
        med_val    = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (cell_q[i].valid && cell_q[i].age == '0)
            begin
                oldest_val = oldest_val | cell_q[i].val;
                oldest_pos = oldest_pos | POS_W'(i);
            end
            if (med_idx == CNT_W'(i))
                med_val = med_val | cell_q[i].val;
        end
    end

    // Update decision
    always_comb
    begin
        ctl.en      = accept;
        ctl.smp     = sample;
        ctl.del_pos = oldest_pos;
        fill_next   = fill_reg;
        if (oldest_val == '0)
        begin
            // zero at the oldest slot: replace it in place
            ctl.del     = 1'b1;
            ctl.dec     = 1'b0;
            ctl.new_age = '0;
        end
        else if (fill_reg < len_eff)
        begin
            // still filling: append
            ctl.del     = 1'b0;
            ctl.dec     = 1'b0;
            ctl.new_age = AGE_W'(fill_reg);
            fill_next   = fill_reg + CNT_W'(1);
        end
        else
        begin
            // full (or length lowered): evict oldest, append
            ctl.del     = 1'b1;
            ctl.dec     = 1'b1;
            ctl.new_age = AGE_W'(fill_reg - CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= CNT_W'(1);
        else if (accept)
            fill_reg <= fill_next;
    end

    assign median = med_val;
    assign fill   = FILL_W'(fill_reg);

`ifndef SYNTHESIS
    // Valid cells track the fill count exactly.
    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_reg))
        else $error("cell valid count differs from fill");

    // Fill stays within 1..MAX_WINDOW.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != '0 && int'(fill_reg) <= MAX_WINDOW)
        else $error("fill out of range");

    // An accepted sample always produces a pending result.
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted sample without result");

    // The row never changes while a result is stalled.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(fill_reg) && $stable(valid_vec))
        else $error("window changed under a stalled result");
`endif

endmodule

// File: rtl/swm_cell.sv
module swm_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  swm_pkg::swm_ctl_t   ctl,
    input  swm_pkg::swm_entry_t left_q,
    input  swm_pkg::swm_entry_t right_q,
    output swm_pkg::swm_entry_t q
);
    import swm_pkg::*;

    localparam logic [POS_W-1:0] POS_SELF = POS_W'(IDX);
    localparam logic [POS_W-1:0] POS_LEFT = POS_W'((IDX > 0) ? IDX - 1 : 0);

    swm_entry_t ent_reg, ent_next;
    swm_entry_t c_own, c_left, fresh;
    logic       lt_own, lt_left;

    always_comb
    begin
        // Close the gap left by the dropped entry.
        c_own  = (!ctl.del || (POS_SELF < ctl.del_pos)) ? ent_reg : right_q;
        c_left = (!ctl.del || (POS_LEFT < ctl.del_pos)) ? left_q : ent_reg;
        if (ctl.dec)
        begin
            c_own.age  = c_own.age - AGE_W'(1);
            c_left.age = c_left.age - AGE_W'(1);
        end

        fresh.valid = 1'b1;
        fresh.val   = ctl.smp;
        fresh.age   = ctl.new_age;

        lt_own  = c_own.valid && (c_own.val <= ctl.smp);
        lt_left = (IDX > 0) && c_left.valid && (c_left.val <= ctl.smp);

        // Open a slot for the new sample.
        if (lt_own)
            ent_next = c_own;
        else if (IDX == 0 || lt_left)
            ent_next = fresh;
        else
            ent_next = c_left;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg.valid <= (IDX == 0);
            ent_reg.val   <= '0;
            ent_reg.age   <= '0;
        end
        else if (ctl.en)
        begin
            ent_reg <= ent_next;
        end
    end

    assign q = ent_reg;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import swm_pkg::*;

    localparam int WINDOW_DEPTH = 64;

    // paddr 4 decodes to no register; a write there must leave window_length alone.
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    localparam int PHASES     = 12;
    localparam int PHASE_BEATS = 88;

    typedef struct packed {
        logic signed [SMP_W-1:0] median;
        logic [FILL_W-1:0]       fill;
    } window_result_t;

    // Scoreboard: keeps its own copy of the window and length register, turns
    // each accepted sample beat into the expected median/fill, and checks the
    // result beats in order.
    class median_scoreboard;
        logic [LEN_W-1:0]        length_reg;
        logic signed [SMP_W-1:0] window [0:WINDOW_DEPTH-1];
        int                      fill_cnt;
        window_result_t          expected_q [$];
        int unsigned             errors;
        int unsigned             samples_seen;
        int unsigned             results_seen;

        function new();
            length_reg = LEN_RESET;
            foreach (window[i])
                window[i] = '0;
            fill_cnt     = 1;
            errors       = 0;
            samples_seen = 0;
            results_seen = 0;
        endfunction

        function void set_length(logic [LEN_W-1:0] v);
            length_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_sample(logic signed [SMP_W-1:0] s);
            int                      eff_len;
            int                      j;
            logic signed [SMP_W-1:0] sorted [0:WINDOW_DEPTH-1];
            logic signed [SMP_W-1:0] v;
            window_result_t          r;

            samples_seen++;
            // zero acts as one, anything past the depth acts as the depth
            if (length_reg == 0)
                eff_len = 1;
            else if (int'(length_reg) > WINDOW_DEPTH)
                eff_len = WINDOW_DEPTH;
            else
                eff_len = int'(length_reg);

            if (window[0] == 0)
                window[0] = s;
            else if (fill_cnt < eff_len)
            begin
                window[fill_cnt] = s;
                fill_cnt++;
            end
            else
            begin
                // full, or length dropped below fill: evict oldest, fill holds
                for (int i = 0; i < fill_cnt - 1; i++)
                    window[i] = window[i + 1];
                window[fill_cnt - 1] = s;
            end

            for (int i = 0; i < fill_cnt; i++)
            begin
                v = window[i];
                j = i;
                while (j > 0 && sorted[j - 1] > v)
                begin
                    sorted[j] = sorted[j - 1];
                    j--;
                end
                sorted[j] = v;
            end

            r.median = sorted[fill_cnt / 2];
            r.fill   = FILL_W'(fill_cnt);
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(logic signed [SMP_W-1:0] med, logic [FILL_W-1:0] f);
            window_result_t r;

            results_seen++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $error("unexpected result beat: median %0d fill %0d", med, f);
                return;
            end
            r = expected_q[0];
            expected_q.delete(0);
            if (med !== r.median)
            begin
                errors++;
                $error("median: expected %0d, actual %0d", r.median, med);
            end
            if (f !== r.fill)
            begin
                errors++;
                $error("fill: expected %0d, actual %0d", r.fill, f);
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [SMP_W-1:0] sample;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [SMP_W-1:0] median;
    logic [FILL_W-1:0]       fill;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    median_scoreboard sb = new();

    // Percent chance of an idle burst before a sample beat, and per cycle of
    // an out_ready stall. Zero means a stretch with no idling at all.
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned length_writes;

    sliding_window_median #(
        .MAX_WINDOW (WINDOW_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median),
        .fill      (fill),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (every beat idled and
    // stalled for the longest burst).
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Monitors. Everything the testbench drives changes by NBA at the edge,
    // so values read here are the ones the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_sample(sample);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(median, fill);
    end

    // Result-side backpressure: out_ready drops in random stall bursts.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // One sample beat; valid is held until the block takes it. An optional
    // idle burst comes first. Entered and left at a rising edge.
    task automatic drive_sample(input logic signed [SMP_W-1:0] s);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Setup cycle, access cycle; the write lands on the edge with pready high.
    // A length write is read back in the following cycle.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WINDOW_LENGTH)
        begin
            sb.set_length(data[LEN_W-1:0]);
            length_writes++;
            @(posedge clk);
            if (prdata !== 32'(data[LEN_W-1:0]))
            begin
                sb.errors++;
                $error("prdata: expected %0d, actual %0d", data[LEN_W-1:0], prdata);
            end
        end
    endtask

    // Stop sending and wait for every expected result, so the block is idle
    // before a register write or the end of the run.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Window length for a random phase. Small lengths go first, since the fill
    // never shrinks; later ones sweep up to the top and back down below fill.
    task automatic set_phase_length(input int phase);
        logic [LEN_W-1:0] len;

        case (phase)
            0:       len = LEN_W'(1);
            1:       len = LEN_W'(3);
            2:       len = LEN_W'($urandom_range(4, 8));
            3:       len = LEN_W'($urandom_range(9, 31));
            4:       len = LEN_W'($urandom_range(32, 63));
            5:       len = LEN_W'(64);
            6:       len = LEN_W'(127);
            7:       len = LEN_W'($urandom_range(65, 126));
            8:       len = LEN_W'($urandom_range(1, 63));
            9:       len = LEN_W'(0);
            10:      len = LEN_W'(64);
            default: len = LEN_W'($urandom_range(1, 127));
        endcase
        // junk in the unused upper bits must be dropped
        reg_write(ADDR_WINDOW_LENGTH, ($urandom() << LEN_W) | 32'(len));
    endtask

    initial
    begin
        logic signed [SMP_W-1:0] s;
        int unsigned             pick;

        rst_n         = 1'b0;
        in_valid      <= 1'b0;
        sample        <= '0;
        out_ready     <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        idle_pct      = 0;
        stall_pct     = 0;
        length_writes = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset length 64. Window starts as one zero entry: a zero
        // sample and then 127 both overwrite it in place, -128 appends.
        drive_sample(8'sd0);
        drive_sample(8'sd127);
        drive_sample(-8'sd128);

        // Length zero behaves as one, and is now below the fill of two, so
        // each beat evicts and appends. The zero that walks to the oldest
        // slot gets overwritten in place instead.
        settle();
        reg_write(ADDR_WINDOW_LENGTH, 32'hffff_ff80);
        drive_sample(8'sh55);
        drive_sample(8'sd0);
        drive_sample(-8'sd86);
        drive_sample(8'sd1);
        drive_sample(-8'sd1);
        drive_sample(8'sd0);
        drive_sample(8'sd0);

        // 127 clamps to the full depth; the spare address must be ignored.
        settle();
        reg_write(ADDR_WINDOW_LENGTH, 32'h0000_007f);
        reg_write(ADDR_SPARE, 32'h0000_0001);
        drive_sample(-8'sd128);
        drive_sample(8'sd127);
        drive_sample(8'sd0);
        drive_sample(8'sd2);
        drive_sample(-8'sd2);
        drive_sample(8'sd127);
        drive_sample(-8'sd128);
        drive_sample(8'sd3);

        // Random phases: zeros and near-equal values are favored to hit
        // in-place overwrites and duplicate medians.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            set_phase_length(phase);
            if (phase >= PHASES - 2 || phase % 3 == 1)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            else
            begin
                idle_pct  = 15;
                stall_pct = 8;
            end
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    s = '0;
                else if (pick <= 2)
                    s = SMP_W'($urandom_range(0, 6) - 3);
                else
                    s = SMP_W'($urandom());
                drive_sample(s);
            end
        end

        settle();
        if (sb.pending() != 0)
        begin
            sb.errors++;
            $error("%0d expected results never arrived", sb.pending());
        end

        $display("Covered %0d sample beats and %0d result beats over %0d length settings,",
                 sb.samples_seen, sb.results_seen, length_writes);
        $display("lengths 0, 1, 64, 127 included, with and without idles and stalls.");
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
